/* hdl/ctc_pkg.sv */
`timescale 1ns / 1ps

package ctc_pkg;

   localparam int SEC_W   = 6;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;
   localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
   localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
   localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
   localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;

   localparam logic [SEC_W-1:0]   RST_SEC   = 6'd0;
   localparam logic [MIN_W-1:0]   RST_MIN   = 6'd10;
   localparam logic [HOUR_W-1:0]  RST_HOUR  = 5'd12;
   localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
   localparam logic [MONTH_W-1:0] RST_MONTH = 4'd11;
   localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2020;

   typedef enum logic {
      FUNC_TICK = 1'b0,
      FUNC_SET  = 1'b1
   } func_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
   } time_type;

   typedef struct packed {
      time_type now;
      logic     day_rolled;
   } result_type;

   // Days in a month; unused month codes read as 31.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic [YEAR_W-1:0]  year);
      logic [DAY_W-1:0] len;
      case (month)
         MONTH_FEB: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* hdl/calendar_time_counter.sv */
`timescale 1ns / 1ps

// Calendar clock keeping second, minute, hour, day, month and year. Each
// request beat is either a tick (tuser = 0, add 0..59 seconds, carrying up
// through the year) or a set (tuser = 1, load every field, each saturated
// into its range). Every request returns one response beat with the time
// after the update and, on tuser, a flag for a day rollover. One beat is
// taken every cycle while the skid entry is empty. The response is
// registered in the output register, as the whole carry chain is
// combinational between the request handshake and that register. A
// two-entry output stage keeps the request side open for one more beat
// while the response side stalls. Reset loads 12:10:00 on November 1, 2020.
module calendar_time_counter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // step_seconds[5:0], set_second[11:6], set_minute[17:12], set_hour[22:18],
   // set_day[27:23], set_month[31:28], set_year[45:32], zero fill[47:46]
   input  logic [ctc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func: 0 tick, 1 set
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cur_second[5:0], cur_minute[11:6], cur_hour[16:12], cur_day[21:17],
   // cur_month[25:22], cur_year[39:26]
   output logic [ctc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // day_rolled
   output logic                               rsp_tuser
);

   ctc_pkg::time_type   time_ff, time_in;
   ctc_pkg::result_type result_in;
   ctc_pkg::result_type main_ff, main_in;
   ctc_pkg::result_type skid_ff, skid_in;
   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                accept;

   logic [ctc_pkg::SEC_W-1:0]   step;
   logic [ctc_pkg::SEC_W:0]     sec_sum;
   logic [ctc_pkg::SEC_W-1:0]   in_sec, in_min;
   logic [ctc_pkg::HOUR_W-1:0]  in_hour;
   logic [ctc_pkg::DAY_W-1:0]   in_day;
   logic [ctc_pkg::MONTH_W-1:0] in_month;
   logic [ctc_pkg::YEAR_W-1:0]  in_year;
   logic [ctc_pkg::DAY_W:0]     day_next;
   logic                        rolled;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !skid_valid_ff;

   assign step     = req_tdata[5:0];
   assign in_sec   = req_tdata[11:6];
   assign in_min   = req_tdata[17:12];
   assign in_hour  = req_tdata[22:18];
   assign in_day   = req_tdata[27:23];
   assign in_month = req_tdata[31:28];
   assign in_year  = req_tdata[45:32];

   always_comb begin
      time_in = time_ff;
      rolled  = 1'b0;
      sec_sum = '0;
      day_next = '0;
      if (ctc_pkg::func_type'(req_tuser) == ctc_pkg::FUNC_SET) begin
         time_in.second = (in_sec > ctc_pkg::SEC_MAX) ? ctc_pkg::SEC_MAX : in_sec;
         time_in.minute = (in_min > ctc_pkg::MIN_MAX) ? ctc_pkg::MIN_MAX : in_min;
         time_in.hour   = (in_hour > ctc_pkg::HOUR_MAX) ? ctc_pkg::HOUR_MAX : in_hour;
         time_in.day    = (in_day == '0) ? ctc_pkg::DAY_MIN : in_day;
         time_in.month  = (in_month == '0) ? ctc_pkg::MONTH_MIN :
                          (in_month > ctc_pkg::MONTH_MAX) ? ctc_pkg::MONTH_MAX : in_month;
         time_in.year   = (in_year > ctc_pkg::YEAR_MAX) ? ctc_pkg::YEAR_MAX : in_year;
      end else begin
         sec_sum = {1'b0, time_ff.second}
                 + {1'b0, ((step > ctc_pkg::SEC_MAX) ? ctc_pkg::SEC_MAX : step)};
         if (sec_sum >= 7'd60) begin
            // keep the remainder, carry one minute
            time_in.second = ctc_pkg::SEC_W'(sec_sum - 7'd60);
            if (time_ff.minute >= ctc_pkg::MIN_MAX) begin
               time_in.minute = '0;
               if (time_ff.hour >= ctc_pkg::HOUR_MAX) begin
                  time_in.hour = '0;
                  rolled       = 1'b1;
                  day_next     = {1'b0, time_ff.day} + 6'd1;
                  if (day_next > {1'b0, ctc_pkg::month_len(time_ff.month, time_ff.year)})
                  begin
                     time_in.day = ctc_pkg::DAY_MIN;
                     if (time_ff.month >= ctc_pkg::MONTH_MAX) begin
                        time_in.month = ctc_pkg::MONTH_MIN;
                        time_in.year  = (time_ff.year >= ctc_pkg::YEAR_MAX) ? '0 :
                                        time_ff.year + 14'd1;
                     end else begin
                        time_in.month = time_ff.month + 4'd1;
                     end
                  end else begin
                     time_in.day = day_next[ctc_pkg::DAY_W-1:0];
                  end
               end else begin
                  time_in.hour = time_ff.hour + 5'd1;
               end
            end else begin
               time_in.minute = time_ff.minute + 6'd1;
            end
         end else begin
            time_in.second = sec_sum[ctc_pkg::SEC_W-1:0];
         end
      end
      result_in.now        = time_in;
      result_in.day_rolled = rolled;
   end

   // Output register plus skid entry.
   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_valid_ff && !rsp_tready) begin
         if (accept) begin
            skid_in       = result_in;
            skid_valid_in = 1'b1;
         end
      end else if (skid_valid_ff) begin
         main_in       = skid_ff;
         main_valid_in = 1'b1;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         main_in       = result_in;
         main_valid_in = 1'b1;
      end else begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '{year:   ctc_pkg::RST_YEAR,  month:  ctc_pkg::RST_MONTH,
                      day:    ctc_pkg::RST_DAY,   hour:   ctc_pkg::RST_HOUR,
                      minute: ctc_pkg::RST_MIN,   second: ctc_pkg::RST_SEC};
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            time_ff <= time_in;
         end
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_ff.now;
   assign rsp_tuser  = main_ff.day_rolled;

   // Skid entry is only ever filled behind a stalled output beat.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry holds a beat while output register is empty");

   // A rollover beat always shows hour and minute zero on the new day.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
      (main_ff.now.hour == '0 && main_ff.now.minute == '0 &&
       main_ff.now.day == ctc_pkg::DAY_MIN || main_ff.now.hour == '0 &&
       main_ff.now.minute == '0 && main_ff.now.day > ctc_pkg::DAY_MIN))
      else $error("day rollover reported away from midnight");

   // Stored date stays in range.
   assert property (@(posedge clock) disable iff (reset)
      time_ff.month >= ctc_pkg::MONTH_MIN && time_ff.month <= ctc_pkg::MONTH_MAX &&
      time_ff.day != '0 && time_ff.year <= ctc_pkg::YEAR_MAX &&
      time_ff.hour <= ctc_pkg::HOUR_MAX && time_ff.second <= ctc_pkg::SEC_MAX)
      else $error("calendar state out of range");

   // A set beat never reports a rollover.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser && !main_valid_ff && !skid_valid_ff) |=>
      (rsp_tvalid && !rsp_tuser))
      else $error("set beat reported a day rollover");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import ctc_pkg::*;

   localparam int DIR_ROWS   = 26;
   localparam int RAND_ITEMS = 800;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 200;
   localparam int TAIL_WAIT  = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   calendar_time_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   typedef struct {
      func_type              func;
      logic [REQ_DATA_W-1:0] data;
      bit                    typed;
      result_type            want;
   } req_beat_type;

   typedef struct {
      func_type func;
      int       step, sec, mnt, hr, dy, mon, yr;
      bit       typed;
      int       e_sec, e_min, e_hour, e_day, e_month, e_year, e_roll;
   } dir_row_type;

   // Rows with typed results are checked against the literal, the rest
   // against the calendar predictor.
   dir_row_type dir_table [DIR_ROWS] = '{
      // reset value, step saturation, minute carry with remainder
      '{FUNC_TICK,  0,  0,  0,  0,  0,  0,     0, 1,  0, 10, 12,  1, 11, 2020, 0},
      '{FUNC_TICK, 63,  0,  0,  0,  0,  0,     0, 1, 59, 10, 12,  1, 11, 2020, 0},
      '{FUNC_TICK,  1,  0,  0,  0,  0,  0,     0, 1,  0, 11, 12,  1, 11, 2020, 0},
      // all set fields above range, then wrap past the last year
      '{FUNC_SET,   0, 63, 63, 31, 31, 15, 16383, 1, 59, 59, 23, 31, 12, 9999, 0},
      '{FUNC_TICK,  1,  0,  0,  0,  0,  0,     0, 1,  0,  0,  0,  1,  1,    0, 1},
      '{FUNC_SET,  63,  0,  0,  0,  0,  0,     0, 1,  0,  0,  0,  1,  1,    0, 0},
      // hour carry without a day carry
      '{FUNC_SET,   0, 50, 59, 10,  5,  5,     5, 1, 50, 59, 10,  5,  5,    5, 0},
      '{FUNC_TICK, 10,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0},
      // leap February
      '{FUNC_SET,   0, 59, 59, 23, 28,  2,  2024, 1, 59, 59, 23, 28,  2, 2024, 0},
      '{FUNC_TICK,  1,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0},
      '{FUNC_SET,   0, 59, 59, 23, 29,  2,  2024, 1, 59, 59, 23, 29,  2, 2024, 0},
      '{FUNC_TICK,  1,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0},
      // common February
      '{FUNC_SET,   0, 58, 59, 23, 28,  2,  2023, 1, 58, 59, 23, 28,  2, 2023, 0},
      '{FUNC_TICK,  2,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0},
      // day past the month length
      '{FUNC_SET,   0, 30, 59, 23, 31,  4,  2021, 1, 30, 59, 23, 31,  4, 2021, 0},
      '{FUNC_TICK, 30,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0},
      // thirty-day months, large remainder
      '{FUNC_SET,   0, 59, 59, 23, 30,  6,  1999, 1, 59, 59, 23, 30,  6, 1999, 0},
      '{FUNC_TICK, 59,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0},
      '{FUNC_SET,   0, 59, 59, 23, 30,  9,  2100, 1, 59, 59, 23, 30,  9, 2100, 0},
      '{FUNC_TICK, 59,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0},
      // year end
      '{FUNC_SET,   0, 45, 59, 23, 31, 12,  2020, 1, 45, 59, 23, 31, 12, 2020, 0},
      '{FUNC_TICK, 20,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0},
      // month and year just above range, then zero month
      '{FUNC_SET,   0,  1,  2,  3,  4, 13, 10000, 1,  1,  2,  3,  4, 12, 9999, 0},
      '{FUNC_TICK,  0,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0},
      '{FUNC_SET,   5, 63, 63, 24, 31,  0,  9999, 1, 59, 59, 23, 31,  1, 9999, 0},
      '{FUNC_TICK,  1,  0,  0,  0,  0,  0,     0, 0,  0,  0,  0,  0,  0,    0, 0}
   };

   req_beat_type req_beats[$];
   result_type   expected_times[$];
   int           mismatches = 0;
   bit           stim_done = 1'b0;

   // calendar state as the block should hold it
   int cal_sec, cal_min, cal_hour, cal_day, cal_month, cal_year;

   function automatic int clip(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int days_in_month(int mon, int yr);
      case (mon)
         2:             return (yr % 4 == 0) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_req(int step, int sec, int mnt, int hr,
                                                      int dy, int mon, int yr);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[5:0]   = step[5:0];
      d[11:6]  = sec[5:0];
      d[17:12] = mnt[5:0];
      d[22:18] = hr[4:0];
      d[27:23] = dy[4:0];
      d[31:28] = mon[3:0];
      d[45:32] = yr[13:0];
      return d;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_tick_data(int step);
      logic [REQ_DATA_W-1:0] d;
      d = REQ_DATA_W'({$urandom, $urandom});
      d[5:0]   = step[5:0];
      d[47:46] = 2'b00;
      return d;
   endfunction

   function automatic result_type advance_calendar(func_type func,
                                                   logic [REQ_DATA_W-1:0] d);
      result_type r;
      int         sum;
      logic       rolled;
      rolled = 1'b0;
      if (func == FUNC_SET) begin
         cal_sec   = clip(int'(d[11:6]), 0, 59);
         cal_min   = clip(int'(d[17:12]), 0, 59);
         cal_hour  = clip(int'(d[22:18]), 0, 23);
         cal_day   = clip(int'(d[27:23]), 1, 31);
         cal_month = clip(int'(d[31:28]), 1, 12);
         cal_year  = clip(int'(d[45:32]), 0, 9999);
      end else begin
         sum = cal_sec + clip(int'(d[5:0]), 0, 59);
         if (sum >= 60) begin
            cal_sec = sum - 60;
            cal_min++;
            if (cal_min >= 60) begin
               cal_min = 0;
               cal_hour++;
               if (cal_hour >= 24) begin
                  cal_hour = 0;
                  rolled = 1'b1;
                  // a day loaded past the month length also lands here
                  cal_day++;
                  if (cal_day > days_in_month(cal_month, cal_year)) begin
                     cal_day = 1;
                     if (cal_month >= 12) begin
                        cal_month = 1;
                        cal_year = (cal_year >= 9999) ? 0 : cal_year + 1;
                     end else begin
                        cal_month++;
                     end
                  end
               end
            end
         end else begin
            cal_sec = sum;
         end
      end
      r.now.second = cal_sec[SEC_W-1:0];
      r.now.minute = cal_min[MIN_W-1:0];
      r.now.hour   = cal_hour[HOUR_W-1:0];
      r.now.day    = cal_day[DAY_W-1:0];
      r.now.month  = cal_month[MONTH_W-1:0];
      r.now.year   = cal_year[YEAR_W-1:0];
      r.day_rolled = rolled;
      return r;
   endfunction

   task automatic add_beat(func_type func, logic [REQ_DATA_W-1:0] d, bit typed,
                           result_type want);
      req_beat_type b;
      b.func  = func;
      b.data  = d;
      b.typed = typed;
      b.want  = want;
      req_beats.push_back(b);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // request side: build the stimulus, then offer it in bursts
   initial begin
      result_type want;
      int         idx, burst_left, gap_left, drain_a, drain_b;
      int         pick, mon, yr, dy, runs;
      int         yr_case;

      cal_sec   = int'(RST_SEC);
      cal_min   = int'(RST_MIN);
      cal_hour  = int'(RST_HOUR);
      cal_day   = int'(RST_DAY);
      cal_month = int'(RST_MONTH);
      cal_year  = int'(RST_YEAR);

      for (int i = 0; i < DIR_ROWS; i++) begin
         want.now.second = dir_table[i].e_sec[SEC_W-1:0];
         want.now.minute = dir_table[i].e_min[MIN_W-1:0];
         want.now.hour   = dir_table[i].e_hour[HOUR_W-1:0];
         want.now.day    = dir_table[i].e_day[DAY_W-1:0];
         want.now.month  = dir_table[i].e_month[MONTH_W-1:0];
         want.now.year   = dir_table[i].e_year[YEAR_W-1:0];
         want.day_rolled = dir_table[i].e_roll[0];
         add_beat(dir_table[i].func,
                  pack_req(dir_table[i].step, dir_table[i].sec, dir_table[i].mnt,
                           dir_table[i].hr, dir_table[i].dy, dir_table[i].mon,
                           dir_table[i].yr),
                  dir_table[i].typed, want);
      end

      want = '0;
      while (req_beats.size() < DIR_ROWS + RAND_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            // load a time near a day, month or year boundary, then push past it
            mon = $urandom_range(1, 12);
            yr_case = $urandom_range(0, 3);
            case (yr_case)
               0:       yr = 9999;
               1:       yr = 4 * $urandom_range(0, 2499);
               default: yr = $urandom_range(0, 9999);
            endcase
            case ($urandom_range(0, 3))
               0:       dy = 31;
               1:       dy = days_in_month(mon, yr) - 1;
               default: dy = days_in_month(mon, yr);
            endcase
            if ($urandom_range(0, 5) == 0) begin
               mon = 12;
               dy  = 31;
            end
            add_beat(FUNC_SET,
                     pack_req($urandom_range(0, 63), $urandom_range(30, 59),
                              $urandom_range(57, 59), $urandom_range(22, 23), dy, mon, yr),
                     1'b0, want);
            runs = $urandom_range(1, 8);
            repeat (runs) add_beat(FUNC_TICK, random_tick_data($urandom_range(40, 63)),
                                   1'b0, want);
         end else if (pick <= 7) begin
            runs = $urandom_range(1, 10);
            repeat (runs) add_beat(FUNC_TICK, random_tick_data($urandom_range(0, 63)),
                                   1'b0, want);
         end else if (pick == 8) begin
            yr = $urandom_range(0, 9999);
            mon = $urandom_range(1, 12);
            add_beat(FUNC_SET,
                     pack_req($urandom_range(0, 63), $urandom_range(0, 59),
                              $urandom_range(0, 59), $urandom_range(0, 23),
                              $urandom_range(1, days_in_month(mon, yr)), mon, yr),
                     1'b0, want);
         end else begin
            // raw bits, out-of-range fields included
            add_beat(FUNC_SET, random_tick_data($urandom_range(0, 63)), 1'b0, want);
         end
      end

      idx        = 0;
      burst_left = 0;
      gap_left   = 0;
      drain_a    = DIR_ROWS;
      drain_b    = DIR_ROWS + RAND_ITEMS / 2;

      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (req_tvalid && req_tready) begin
            want = advance_calendar(req_beats[idx].func, req_beats[idx].data);
            if (req_beats[idx].typed) want = req_beats[idx].want;
            expected_times.push_back(want);
            idx++;
            if (burst_left > 0) burst_left--;
         end
         // hold an offered beat until it is taken
         if (!req_tvalid || req_tready) begin
            if (idx == req_beats.size()) begin
               req_tvalid <= 1'b0;
               break;
            end
            if (burst_left == 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(40, 120);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = $urandom_range(1, 6);
               end
            end
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if ((idx == drain_a || idx == drain_b) && expected_times.size() != 0) begin
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= req_beats[idx].data;
               req_tuser  <= req_beats[idx].func;
            end
         end
      end
      stim_done = 1'b1;
   end

   // response side: check each beat, stall on a pattern of its own
   initial begin
      result_type want;
      time_type   got;
      int         rsp_seen, hold_left, mode, mode_left;
      bit         long_hold_done;

      rsp_seen       = 0;
      hold_left      = 0;
      mode           = 0;
      mode_left      = 0;
      long_hold_done = 1'b0;

      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_times.size() == 0) begin
               $display("%0t: response beat with nothing pending, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_times.pop_front();
               got  = time_type'(rsp_tdata);
               check_field("second", int'(want.now.second), int'(got.second));
               check_field("minute", int'(want.now.minute), int'(got.minute));
               check_field("hour", int'(want.now.hour), int'(got.hour));
               check_field("day", int'(want.now.day), int'(got.day));
               check_field("month", int'(want.now.month), int'(got.month));
               check_field("year", int'(want.now.year), int'(got.year));
               check_field("day_rolled", int'(want.day_rolled), int'(rsp_tuser));
            end
            rsp_seen++;
         end
         if (!long_hold_done && rsp_seen >= 300) begin
            // back up the block so the request side stalls
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (mode_left % 5 != 0);
            endcase
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("[calendar_time_counter] ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      while (expected_times.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("[calendar_time_counter] OK");
      end else begin
         $display("[calendar_time_counter] ERROR");
      end
      $finish;
   end

endmodule
